@@ sv/kta_pkg.sv @@
// shared types and codes of the keyframe track animator
package kta_pkg;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 64;
  localparam int DIV_STEPS   = 40;

  localparam logic [23:0] TMAX = 24'hFFFFFF;

  localparam logic [2:0] FN_LOAD    = 3'd0;
  localparam logic [2:0] FN_CLEAR   = 3'd1;
  localparam logic [2:0] FN_PLAY    = 3'd2;
  localparam logic [2:0] FN_PAUSE   = 3'd3;
  localparam logic [2:0] FN_RESUME  = 3'd4;
  localparam logic [2:0] FN_STOP    = 3'd5;
  localparam logic [2:0] FN_TICK    = 3'd6;
  localparam logic [2:0] FN_SETTIME = 3'd7;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_VALUE  = 2'd2;
  localparam logic [1:0] ST_NOPLAY = 2'd3;

  localparam logic [1:0] RS_STOPPED  = 2'd0;
  localparam logic [1:0] RS_PLAYING  = 2'd1;
  localparam logic [1:0] RS_PAUSED   = 2'd2;
  localparam logic [1:0] RS_FINISHED = 2'd3;

  localparam logic [2:0] PM_ONCE     = 3'd0;
  localparam logic [2:0] PM_LOOP     = 3'd1;
  localparam logic [2:0] PM_PINGPONG = 3'd2;
  localparam logic [2:0] PM_REVONCE  = 3'd3;
  localparam logic [2:0] PM_REVLOOP  = 3'd4;

  localparam logic [2:0] EM_LINEAR = 3'd0;
  localparam logic [2:0] EM_IN     = 3'd1;
  localparam logic [2:0] EM_OUT    = 3'd2;
  localparam logic [2:0] EM_INOUT  = 3'd3;
  localparam logic [2:0] EM_SMOOTH = 3'd4;
  localparam logic [2:0] EM_STEP   = 3'd5;

  typedef struct packed {
    logic [2:0]  ease;
    logic [31:0] value;
    logic [23:0] kt;
  } key_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  sel;
    logic [23:0] ktime;
    logic [31:0] kval;
    logic [2:0]  emode;
    logic [2:0]  pmode;
    logic [15:0] speed;
    logic [15:0] delta;
  } in_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [2:0]  trk;
    logic [31:0] val;
    logic [1:0]  run;
    logic [23:0] tm;
    logic        lp;
    logic        last;
  } res_t;

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_DEC   = 20'h00002,
    S_CMD   = 20'h00004,
    S_TSCAN = 20'h00008,
    S_TMUL  = 20'h00010,
    S_TADV  = 20'h00020,
    S_TDIV  = 20'h00040,
    S_TFIN  = 20'h00080,
    S_TWR   = 20'h00100,
    S_K0    = 20'h00200,
    S_K0W   = 20'h00400,
    S_KLW   = 20'h00800,
    S_KSW   = 20'h01000,
    S_EDIV  = 20'h02000,
    S_E1    = 20'h04000,
    S_E2    = 20'h08000,
    S_E3    = 20'h10000,
    S_E4    = 20'h20000,
    S_E5    = 20'h40000,
    S_EMIT  = 20'h80000
  } state_e;

endpackage

@@ sv/keyframe_track_animator.sv @@
// keyframe track animator top level
// Commands other than set time and tick update the track record and emit one result.
// Set time and every playing track of a tick run a sequencer over the key memory: a
// bracket search over the keyframes and, if the time falls between two keys, one pass of
// the shared restoring divider for the interpolation fraction and the easing states E1 to
// E5. A tick first advances each playing track's time, with one more divider pass for
// ping-pong steps and for loop and reverse-loop wraps. Track state sits in a track memory
// with per-entry valid bits, keyframes in the key memory.
module keyframe_track_animator
  import kta_pkg::*;
#(
  parameter int TRACKS         = 8,
  parameter int KEYS_PER_TRACK = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // track_sel, key_time, key_value, ease_mode, play_mode, speed, delta_time
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // func
  input  logic [2:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // track_out, value_out, run_state, current_time, looped
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [1:0]             m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int TW  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int CW  = $clog2(KEYS_PER_TRACK + 1);
  localparam int KIW = $clog2(KEYS_PER_TRACK);
  localparam int KD  = TRACKS * KEYS_PER_TRACK;
  localparam int KAW = $clog2(KD);

  typedef struct packed {
    logic          active;
    logic [1:0]    status;
    logic [2:0]    mode;
    logic [15:0]   speed;
    logic [23:0]   tm;
    logic [23:0]   dur;
    logic          dir;
    logic          lpf;
    logic [CW-1:0] cnt;
  } trk_t;

  localparam trk_t TRK_RST = '{active: 1'b0, status: RS_STOPPED, mode: PM_ONCE,
                               speed: 16'd256, tm: 24'd0, dur: 24'd0, dir: 1'b0,
                               lpf: 1'b0, cnt: '0};

  state_e state_q, state_d;
  in_t    in_q, in_d;
  res_t   res_q, res_d, out_q, out_d;
  logic   ovalid_q, ovalid_d;
  logic [TRACKS-1:0] play_vec_q, play_vec_d, trk_vld_q, trk_vld_d;
  logic [TW-1:0] trk_q, trk_d;
  trk_t   rec_q, rec_d;
  logic [23:0] step_q, step_d;
  logic   ph_hi_q, ph_hi_d;
  logic [CW-1:0] idx_q, idx_d;
  key_t   prev_q, prev_d;
  logic [31:0] lastv_q, lastv_d, b_q, b_d;
  logic [15:0] u_q, u_d;
  logic [33:0] sq_q, sq_d;
  logic [49:0] m2_q, m2_d;
  logic [16:0] e_q, e_d;
  logic signed [50:0] prod_q, prod_d;
  logic [39:0] div_quo_q, div_quo_d;
  logic [23:0] div_rem_q, div_rem_d, div_dv_q, div_dv_d;
  logic [5:0]  div_cnt_q, div_cnt_d;

  trk_t   trk_mem [TRACKS];
  trk_t   trk_rd_q, trk_wd, cur;
  logic   trk_vrd_q, trk_we;
  logic [TW-1:0] trk_ra, trk_wa;

  key_t   key_mem [KD];
  key_t   key_rd_q, key_wd;
  logic   key_we;
  logic [KAW-1:0] key_ra, key_wa;

  logic   div_ld;
  logic [39:0] div_nd;
  logic [23:0] div_dv;
  logic [25:0] div_trial;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {2'b00, out_q.lp, out_q.tm, out_q.run, out_q.val, out_q.trk};
  assign m_axis_tuser  = out_q.st;
  assign m_axis_tlast  = out_q.last;

  assign cur    = trk_vrd_q ? trk_rd_q : TRK_RST;
  assign trk_ra = (state_q == S_DEC) ? TW'(in_q.sel) : trk_q;

  always_ff @(posedge clk_i) begin
    if (trk_we) begin
      trk_mem[trk_wa] <= trk_wd;
    end
    trk_rd_q  <= trk_mem[trk_ra];
    trk_vrd_q <= trk_vld_q[trk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    key_rd_q <= key_mem[key_ra];
  end

  always_comb begin
    trk_t          rec;
    logic [1:0]    st;
    logic [24:0]   s_sum, d2, ph;
    logic [23:0]   s_sat, p, dd, tmv;
    logic [25:0]   tot;
    logic [16:0]   x;
    logic [17:0]   w18;
    logic [32:0]   dab;
    logic [CW-1:0] kix;
    logic          more;

    state_d    = state_q;
    in_d       = in_q;
    res_d      = res_q;
    out_d      = out_q;
    ovalid_d   = ovalid_q;
    play_vec_d = play_vec_q;
    trk_vld_d  = trk_vld_q;
    trk_d      = trk_q;
    rec_d      = rec_q;
    step_d     = step_q;
    ph_hi_d    = ph_hi_q;
    idx_d      = idx_q;
    prev_d     = prev_q;
    lastv_d    = lastv_q;
    b_d        = b_q;
    u_d        = u_q;
    sq_d       = sq_q;
    m2_d       = m2_q;
    e_d        = e_q;
    prod_d     = prod_q;
    trk_we     = 1'b0;
    trk_wa     = trk_q;
    trk_wd     = rec_q;
    key_we     = 1'b0;
    key_wd     = '{ease: in_q.emode, value: in_q.kval, kt: in_q.ktime};
    div_ld     = 1'b0;
    div_nd     = '0;
    div_dv     = '0;
    kix        = '0;
    rec        = cur;
    st         = ST_DONE;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    more = 1'b0;
    for (int j = 0; j < TRACKS; j++) begin
      if (play_vec_q[j] && (j > int'(trk_q))) begin
        more = 1'b1;
      end
    end

    // advance arithmetic on the working record
    dd    = rec_q.dur;
    tmv   = rec_q.tm;
    s_sum = {1'b0, tmv} + {1'b0, step_q};
    s_sat = s_sum[24] ? TMAX : s_sum[23:0];
    d2    = {dd, 1'b0};
    p     = (tmv < dd) ? tmv : dd;
    ph    = rec_q.dir ? (d2 - {1'b0, p}) : {1'b0, p};
    if (ph >= d2) begin
      ph = '0;
    end
    tot   = {1'b0, ph} + {2'b00, step_q};
    w18   = 18'd196608 - {1'b0, u_q, 1'b0};
    dab   = {b_q[31], b_q} - {prev_q.value[31], prev_q.value};
    x     = {1'b0, div_quo_q[15:0]};

    key_wa = KAW'(trk_q * KEYS_PER_TRACK) + KAW'(cur.cnt[KIW-1:0]);

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          in_d = '{func: s_axis_tuser, sel: s_axis_tdata[2:0], ktime: s_axis_tdata[26:3],
                   kval: s_axis_tdata[58:27], emode: s_axis_tdata[61:59],
                   pmode: s_axis_tdata[64:62], speed: s_axis_tdata[80:65],
                   delta: s_axis_tdata[96:81]};
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (in_q.func == FN_TICK) begin
          trk_d = '0;
          if (play_vec_q == '0) begin
            res_d   = '{st: ST_NOPLAY, trk: 3'd0, val: 32'd0, run: RS_STOPPED, tm: 24'd0,
                        lp: 1'b0, last: 1'b1};
            state_d = S_EMIT;
          end else begin
            state_d = S_TSCAN;
          end
        end else if (int'(in_q.sel) >= TRACKS) begin
          res_d   = '{st: ST_REJECT, trk: in_q.sel, val: 32'd0, run: RS_STOPPED, tm: 24'd0,
                      lp: 1'b0, last: 1'b1};
          state_d = S_EMIT;
        end else begin
          trk_d   = TW'(in_q.sel);
          state_d = S_CMD;
        end
      end
      S_CMD: begin
        if (in_q.func == FN_LOAD) begin
          if (!rec.active) begin
            rec        = TRK_RST;
            rec.active = 1'b1;
          end
          if (rec.cnt >= CW'(KEYS_PER_TRACK)) begin
            st = ST_REJECT;
          end else begin
            key_we = 1'b1;
            key_wa = KAW'(trk_q * KEYS_PER_TRACK) + KAW'(rec.cnt[KIW-1:0]);
            rec.cnt = rec.cnt + 1'b1;
            if (in_q.ktime > rec.dur) begin
              rec.dur = in_q.ktime;
            end
          end
        end else if (!rec.active) begin
          st = ST_REJECT;
        end else begin
          case (in_q.func)
            FN_CLEAR: rec = TRK_RST;
            FN_PLAY: begin
              if (in_q.pmode > PM_REVLOOP) begin
                st = ST_REJECT;
              end else begin
                rec.mode   = in_q.pmode;
                rec.speed  = in_q.speed;
                rec.status = RS_PLAYING;
                rec.lpf    = 1'b0;
                rec.dir    = 1'b0;
                rec.tm     = (in_q.pmode == PM_REVONCE || in_q.pmode == PM_REVLOOP) ?
                             rec.dur : 24'd0;
              end
            end
            FN_PAUSE: begin
              if (rec.status == RS_PLAYING) begin
                rec.status = RS_PAUSED;
              end
            end
            FN_RESUME: begin
              if (rec.status == RS_PAUSED) begin
                rec.status = RS_PLAYING;
              end
            end
            FN_STOP: begin
              rec.status = RS_STOPPED;
              rec.tm     = 24'd0;
              rec.dir    = 1'b0;
            end
            FN_SETTIME: begin
              rec.tm = in_q.ktime;
              st     = ST_VALUE;
            end
            default: begin
            end
          endcase
        end
        trk_we            = 1'b1;
        trk_wd            = rec;
        play_vec_d[trk_q] = rec.active && (rec.status == RS_PLAYING);
        trk_vld_d[trk_q]  = 1'b1;
        rec_d             = rec;
        res_d = '{st: st, trk: in_q.sel, val: 32'd0, run: rec.status, tm: rec.tm,
                  lp: 1'b0, last: 1'b1};
        state_d = (st == ST_VALUE) ? S_K0 : S_EMIT;
      end
      S_TSCAN: begin
        if (play_vec_q[trk_q]) begin
          state_d = S_TMUL;
        end else if (int'(trk_q) >= TRACKS - 1) begin
          state_d = S_IDLE;
        end else begin
          trk_d = TW'(trk_q + 1'b1);
        end
      end
      S_TMUL: begin
        rec_d   = cur;
        step_d  = 24'((32'(in_q.delta) * 32'(cur.speed)) >> 8);
        state_d = S_TADV;
      end
      S_TADV: begin
        state_d     = S_TWR;
        rec_d.lpf   = 1'b0;
        if (dd == 24'd0) begin
          rec_d.tm = 24'd0;
        end else begin
          case (rec_q.mode)
            PM_ONCE: begin
              if (s_sat >= dd) begin
                rec_d.tm     = dd;
                rec_d.status = RS_FINISHED;
              end else begin
                rec_d.tm = s_sat;
              end
            end
            PM_LOOP: begin
              if (s_sat >= dd) begin
                div_ld  = 1'b1;
                div_nd  = 40'(s_sat);
                div_dv  = dd;
                state_d = S_TDIV;
              end else begin
                rec_d.tm = s_sat;
              end
            end
            PM_PINGPONG: begin
              div_ld  = 1'b1;
              div_nd  = 40'(tot);
              div_dv  = dd;
              ph_hi_d = (ph >= {1'b0, dd});
              state_d = S_TDIV;
            end
            PM_REVONCE: begin
              if (step_q >= tmv) begin
                rec_d.tm     = 24'd0;
                rec_d.status = RS_FINISHED;
              end else begin
                rec_d.tm = tmv - step_q;
              end
            end
            default: begin
              if (step_q >= tmv) begin
                div_ld  = 1'b1;
                div_nd  = 40'(step_q - tmv);
                div_dv  = dd;
                state_d = S_TDIV;
              end else begin
                rec_d.tm = tmv - step_q;
              end
            end
          endcase
        end
      end
      S_TDIV: begin
        if (div_cnt_q == '0) begin
          state_d = S_TFIN;
        end
      end
      S_TFIN: begin
        case (rec_q.mode)
          PM_LOOP: begin
            rec_d.tm  = div_rem_q;
            rec_d.lpf = 1'b1;
          end
          PM_PINGPONG: begin
            rec_d.lpf = (div_quo_q != {39'd0, ph_hi_q});
            rec_d.dir = div_quo_q[0];
            rec_d.tm  = div_quo_q[0] ? (dd - div_rem_q) : div_rem_q;
          end
          default: begin
            rec_d.tm  = dd - div_rem_q;
            rec_d.lpf = 1'b1;
          end
        endcase
        state_d = S_TWR;
      end
      S_TWR: begin
        trk_we            = 1'b1;
        trk_wd            = rec_q;
        play_vec_d[trk_q] = rec_q.active && (rec_q.status == RS_PLAYING);
        trk_vld_d[trk_q]  = 1'b1;
        res_d = '{st: ST_VALUE, trk: 3'(trk_q), val: 32'd0, run: rec_q.status,
                  tm: rec_q.tm, lp: rec_q.lpf, last: !more};
        state_d = S_K0;
      end
      S_K0: begin
        kix = '0;
        if (rec_q.cnt == '0) begin
          res_d.val = 32'd0;
          state_d   = S_EMIT;
        end else begin
          state_d = S_K0W;
        end
      end
      S_K0W: begin
        prev_d = key_rd_q;
        if (tmv <= key_rd_q.kt) begin
          res_d.val = key_rd_q.value;
          state_d   = S_EMIT;
        end else begin
          kix     = rec_q.cnt - 1'b1;
          state_d = S_KLW;
        end
      end
      S_KLW: begin
        lastv_d = key_rd_q.value;
        if (tmv >= key_rd_q.kt) begin
          res_d.val = key_rd_q.value;
          state_d   = S_EMIT;
        end else begin
          idx_d   = '0;
          kix     = CW'(1);
          state_d = S_KSW;
        end
      end
      S_KSW: begin
        if (tmv >= prev_q.kt && tmv < key_rd_q.kt) begin
          div_ld  = 1'b1;
          div_nd  = {tmv - prev_q.kt, 16'd0};
          div_dv  = key_rd_q.kt - prev_q.kt;
          b_d     = key_rd_q.value;
          state_d = S_EDIV;
        end else begin
          prev_d = key_rd_q;
          if (({1'b0, idx_q} + 2'd2) < {1'b0, rec_q.cnt}) begin
            idx_d = idx_q + 1'b1;
            kix   = idx_q + 2'd2;
          end else begin
            res_d.val = lastv_q;
            state_d   = S_EMIT;
          end
        end
      end
      S_EDIV: begin
        if (div_cnt_q == '0) begin
          state_d = S_E1;
        end
      end
      S_E1: begin
        u_d = div_quo_q[15:0];
        if (prev_q.ease == EM_OUT) begin
          x = 17'd65536 - x;
        end else if (prev_q.ease == EM_INOUT && div_quo_q[15]) begin
          x = 17'(18'd131072 - {1'b0, div_quo_q[15:0], 1'b0});
        end
        sq_d    = 34'(x) * 34'(x);
        state_d = S_E2;
      end
      S_E2: begin
        m2_d    = 50'(sq_q[31:0]) * 50'(w18);
        state_d = S_E3;
      end
      S_E3: begin
        case (prev_q.ease)
          EM_IN:     e_d = 17'(sq_q >> 16);
          EM_OUT:    e_d = 17'd65536 - 17'(sq_q >> 16);
          EM_INOUT:  e_d = u_q[15] ? (17'd65536 - 17'(sq_q >> 17)) : 17'(sq_q >> 15);
          EM_SMOOTH: e_d = 17'(m2_q >> 32);
          EM_STEP:   e_d = u_q[15] ? 17'd65536 : 17'd0;
          default:   e_d = {1'b0, u_q};
        endcase
        state_d = S_E4;
      end
      S_E4: begin
        prod_d  = $signed(dab) * $signed({1'b0, e_q});
        state_d = S_E5;
      end
      S_E5: begin
        res_d.val = prev_q.value + prod_q[47:16];
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (!ovalid_q || m_axis_tready) begin
          out_d    = res_q;
          ovalid_d = 1'b1;
          if (in_q.func == FN_TICK && !res_q.last) begin
            trk_d   = TW'(trk_q + 1'b1);
            state_d = S_TSCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    key_ra = KAW'(trk_q * KEYS_PER_TRACK) + KAW'(kix[KIW-1:0]);

    // shared restoring divider, one quotient bit per cycle
    div_quo_d = div_quo_q;
    div_rem_d = div_rem_q;
    div_dv_d  = div_dv_q;
    div_cnt_d = div_cnt_q;
    div_trial = {1'b0, div_rem_q, div_quo_q[39]} - {2'b00, div_dv_q};
    if (div_ld) begin
      div_quo_d = div_nd;
      div_rem_d = '0;
      div_dv_d  = div_dv;
      div_cnt_d = 6'(DIV_STEPS);
    end else if (div_cnt_q != '0) begin
      if (!div_trial[25]) begin
        div_rem_d = div_trial[23:0];
        div_quo_d = {div_quo_q[38:0], 1'b1};
      end else begin
        div_rem_d = {div_rem_q[22:0], div_quo_q[39]};
        div_quo_d = {div_quo_q[38:0], 1'b0};
      end
      div_cnt_d = div_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ovalid_q   <= 1'b0;
      play_vec_q <= '0;
      trk_vld_q  <= '0;
      div_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      ovalid_q   <= ovalid_d;
      play_vec_q <= play_vec_d;
      trk_vld_q  <= trk_vld_d;
      div_cnt_q  <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    res_q     <= res_d;
    out_q     <= out_d;
    trk_q     <= trk_d;
    rec_q     <= rec_d;
    step_q    <= step_d;
    ph_hi_q   <= ph_hi_d;
    idx_q     <= idx_d;
    prev_q    <= prev_d;
    lastv_q   <= lastv_d;
    b_q       <= b_d;
    u_q       <= u_d;
    sq_q      <= sq_d;
    m2_q      <= m2_d;
    e_q       <= e_d;
    prod_q    <= prod_d;
    div_quo_q <= div_quo_d;
    div_rem_q <= div_rem_d;
    div_dv_q  <= div_dv_d;
  end

endmodule

@@ sv/kta_checker.sv @@
// port-level checker of the keyframe track animator and its bind
module kta_checker
  import kta_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [2:0]             s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]             m_axis_tuser,
  input logic                   m_axis_tlast
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_REJECT |-> m_axis_tdata[34:3] == 32'd0
      && m_axis_tlast)
    else $error("rejected result carries a value");

  a_noplay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_NOPLAY |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("no-track result not empty");

  a_looped_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_VALUE |-> !m_axis_tdata[61])
    else $error("looped flag outside track value");

endmodule

bind keyframe_track_animator kta_checker u_kta_checker (.*);
